FILE: hw/rtl/ftsbr_pkg.sv
// ----------------------------------------------------------------------------
// Frame-tagged statistics buffer ring package
// Widths, codes and parameter defaults shared by the buffer ring design.
// ----------------------------------------------------------------------------
`default_nettype none

package ftsbr_pkg;

    localparam int NUM_BUFFERS_DEF  = 3;
    localparam int FRAME_WRAP_DEF   = 16383;
    localparam int FUTURE_LIMIT_DEF = 10;

    localparam int MODE_W   = 2;
    localparam int FRAME_W  = 16;
    localparam int TIME_W   = 64;
    localparam int FIELD_W  = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 3;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    typedef enum logic [MODE_W-1:0] {
        MODE_FRAME_DONE    = 2'd0,
        MODE_STATS_REQUEST = 2'd1,
        MODE_EXTRA_STATS   = 2'd2,
        MODE_CAMERA_NOTIFY = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_NONE     = 3'd0,
        ST_HIT      = 3'd1,
        ST_ARMED    = 3'd2,
        ST_READY    = 3'd3,
        ST_DISABLED = 3'd4,
        ST_NA       = 3'd5
    } status_t;

    localparam logic REG_ENGINE_ENABLED = 1'b0;
    localparam logic REG_BUFFERS_READY  = 1'b1;

endpackage

`default_nettype wire

FILE: hw/rtl/frame_tagged_stats_buffer_ring.sv
// ----------------------------------------------------------------------------
// Frame-tagged statistics buffer ring
// Keeps a small ring of tagged statistics buffers and answers frame-done,
// statistics request, extra-stats update and camera notify events.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake           | Contents
//  --------+-----------+---------------------+----------------------------------
//  in      | input     | in_valid / in_stall | mode and event fields
//  out     | output    | out_valid/out_stall | status, slot, frame and buffer data
//  config  | input     | APB-style           | engine_enabled, buffers_ready
//
//  A request is captured in an input register and processed from there; its
//  result is written into the output register when the request advances.
//  One request is accepted per cycle while the input side does not stall; the
//  ring state is updated once for each request that advances.
//  Reset clears all ring state, the config registers and both valid flags.
//  A stalled result holds the output register and, through it, the input
//  register; the input side stalls only while both are occupied and the
//  result is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_tagged_stats_buffer_ring #(
    parameter int NUM_BUFFERS  = ftsbr_pkg::NUM_BUFFERS_DEF,
    parameter int FRAME_WRAP   = ftsbr_pkg::FRAME_WRAP_DEF,
    parameter int FUTURE_LIMIT = ftsbr_pkg::FUTURE_LIMIT_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ftsbr_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [ftsbr_pkg::PDATA_W-1:0]   pwdata,
    output logic      [ftsbr_pkg::PDATA_W-1:0]   prdata,
    output logic                                 pready,

    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [ftsbr_pkg::MODE_W-1:0]    mode,
    input  wire logic [ftsbr_pkg::FRAME_W-1:0]   frame_wanted,
    input  wire logic                            want_stats,
    input  wire logic [ftsbr_pkg::TIME_W-1:0]    time_value,
    input  wire logic [ftsbr_pkg::FIELD_W-1:0]   field_value,
    input  wire logic                            write_time,
    input  wire logic                            write_field,
    input  wire logic                            camera_off_flag,

    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic      [ftsbr_pkg::STATUS_W-1:0]  status,
    output logic      [ftsbr_pkg::SLOT_W-1:0]    slot,
    output logic      [ftsbr_pkg::FRAME_W-1:0]   granted_frame,
    output logic      [ftsbr_pkg::TIME_W-1:0]    stamp,
    output logic      [ftsbr_pkg::FIELD_W-1:0]   field_out,
    output logic      [ftsbr_pkg::FRAME_W-1:0]   current_frame
);

    import ftsbr_pkg::*;

    localparam int IDX_W = $clog2(NUM_BUFFERS);
    localparam int CMP_W = FRAME_W + 2;
    localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(NUM_BUFFERS - 1);
    localparam logic [FRAME_W-1:0] WRAP_F   = FRAME_W'(FRAME_WRAP);
    localparam logic [CMP_W-1:0]   WRAP_C   = CMP_W'(FRAME_WRAP);
    localparam logic [CMP_W-1:0]   LIMIT_C  = CMP_W'(FUTURE_LIMIT);

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] s);
        logic [IDX_W-1:0] r;
        r = (s == LAST_IDX) ? '0 : s + IDX_W'(1);
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] s);
        logic [IDX_W-1:0] r;
        r = (s == '0) ? LAST_IDX : s - IDX_W'(1);
        return r;
    endfunction

    // Configuration registers.
    logic engine_enabled_reg;
    logic buffers_ready_reg;
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            engine_enabled_reg <= 1'b0;
            buffers_ready_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_ENGINE_ENABLED: engine_enabled_reg <= pwdata[0];
                REG_BUFFERS_READY:  buffers_ready_reg  <= pwdata[0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_ENGINE_ENABLED: prdata = {{(PDATA_W-1){1'b0}}, engine_enabled_reg};
            REG_BUFFERS_READY:  prdata = {{(PDATA_W-1){1'b0}}, buffers_ready_reg};
            default:            prdata = '0;
        endcase
    end

    // Input register.
    logic                 in_valid_reg;
    logic [MODE_W-1:0]    mode_reg;
    logic [FRAME_W-1:0]   frame_wanted_reg;
    logic                 want_stats_reg;
    logic [TIME_W-1:0]    time_value_reg;
    logic [FIELD_W-1:0]   field_value_reg;
    logic                 write_time_reg;
    logic                 write_field_reg;
    logic                 camera_off_reg;

    logic out_valid_reg;
    logic advance;
    logic in_accept;

    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mode_reg         <= mode;
            frame_wanted_reg <= frame_wanted;
            want_stats_reg   <= want_stats;
            time_value_reg   <= time_value;
            field_value_reg  <= field_value;
            write_time_reg   <= write_time;
            write_field_reg  <= write_field;
            camera_off_reg   <= camera_off_flag;
        end
    end

    // Ring state.
    logic                 locked_reg       [NUM_BUFFERS];
    logic [FRAME_W-1:0]   tag_reg          [NUM_BUFFERS];
    logic [TIME_W-1:0]    time_reg         [NUM_BUFFERS];
    logic [FIELD_W-1:0]   field_reg        [NUM_BUFFERS];
    logic [IDX_W-1:0]     active_slot_reg;
    logic [FRAME_W-1:0]   frame_counter_reg;
    logic                 pending_reg;
    logic [FRAME_W-1:0]   requested_frame_reg;
    logic                 camera_off_state_reg;

    logic                 locked_next      [NUM_BUFFERS];
    logic [FRAME_W-1:0]   tag_next         [NUM_BUFFERS];
    logic [TIME_W-1:0]    time_next        [NUM_BUFFERS];
    logic [FIELD_W-1:0]   field_next       [NUM_BUFFERS];
    logic [IDX_W-1:0]     active_slot_next;
    logic [FRAME_W-1:0]   frame_counter_next;
    logic                 pending_next;
    logic [FRAME_W-1:0]   requested_frame_next;
    logic                 camera_off_state_next;

    logic [STATUS_W-1:0]  status_next;
    logic [SLOT_W-1:0]    slot_next;
    logic [FRAME_W-1:0]   granted_next;
    logic [TIME_W-1:0]    stamp_next;
    logic [FIELD_W-1:0]   field_out_next;

    // Shared terms.
    logic [IDX_W-1:0]     act;
    logic [FRAME_W-1:0]   act_tag;
    logic [IDX_W-1:0]     new_act;
    logic [FRAME_W-1:0]   fc_inc;
    logic                 fc_wrap;
    logic [FRAME_W:0]     align;
    logic                 hit;
    logic [IDX_W-1:0]     hit_idx;
    logic [CMP_W-1:0]     fc_c;
    logic [CMP_W-1:0]     fw_c;
    logic [CMP_W-1:0]     diff;
    logic                 too_far;
    logic [FRAME_W-1:0]   granted_miss;
    logic [IDX_W-1:0]     first_idx;
    logic [IDX_W-1:0]     past_idx;

    always_comb
    begin
        act     = active_slot_reg;
        act_tag = tag_reg[act];

        new_act = ring_next(act);
        if (locked_reg[new_act])
        begin
            new_act = ring_next(new_act);
        end
        fc_inc  = frame_counter_reg + FRAME_W'(1);
        fc_wrap = fc_inc > WRAP_F;
        align   = {1'b0, fc_inc} + (FRAME_W+1)'(fc_wrap);

        hit     = 1'b0;
        hit_idx = '0;
        for (int i = NUM_BUFFERS - 1; i >= 0; i--)
        begin
            if (tag_reg[i] == frame_wanted_reg && tag_reg[i] != act_tag)
            begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end

        fc_c = {2'b00, frame_counter_reg};
        fw_c = {2'b00, frame_wanted_reg};
        if (fw_c > fc_c)
        begin
            diff = fw_c - fc_c;
        end
        else if (fw_c < fc_c)
        begin
            if ((fc_c + LIMIT_C > WRAP_C) && (fw_c < WRAP_C))
            begin
                diff = fw_c + WRAP_C - fc_c;
            end
            else
            begin
                diff = LIMIT_C + CMP_W'(1);
            end
        end
        else
        begin
            diff = '0;
        end
        too_far      = diff > LIMIT_C;
        granted_miss = too_far ? frame_counter_reg : frame_wanted_reg;

        first_idx = act;
        for (int i = NUM_BUFFERS - 1; i >= 0; i--)
        begin
            if (tag_reg[i] == act_tag)
            begin
                first_idx = IDX_W'(i);
            end
        end
        past_idx = ring_prev(first_idx);
        if (locked_reg[past_idx])
        begin
            past_idx = ring_prev(past_idx);
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_BUFFERS; i++)
        begin
            locked_next[i] = locked_reg[i];
            tag_next[i]    = tag_reg[i];
            time_next[i]   = time_reg[i];
            field_next[i]  = field_reg[i];
        end
        active_slot_next      = active_slot_reg;
        frame_counter_next    = frame_counter_reg;
        pending_next          = pending_reg;
        requested_frame_next  = requested_frame_reg;
        camera_off_state_next = camera_off_state_reg;

        status_next    = ST_NONE;
        slot_next      = '0;
        granted_next   = '0;
        stamp_next     = '0;
        field_out_next = '0;

        case (mode_t'(mode_reg))
            MODE_FRAME_DONE:
            begin
                if (buffers_ready_reg)
                begin
                    time_next[act]     = time_value_reg;
                    active_slot_next   = new_act;
                    frame_counter_next = fc_wrap ? FRAME_W'(1) : fc_inc;
                    tag_next[new_act]  = frame_counter_next;
                    if (pending_reg && align > {1'b0, requested_frame_reg})
                    begin
                        pending_next = 1'b0;
                        status_next  = ST_READY;
                    end
                end
            end
            MODE_STATS_REQUEST:
            begin
                if (!engine_enabled_reg)
                begin
                    status_next = ST_DISABLED;
                end
                else if (want_stats_reg)
                begin
                    for (int i = 0; i < NUM_BUFFERS; i++)
                    begin
                        locked_next[i] = 1'b0;
                    end
                    if (hit)
                    begin
                        locked_next[hit_idx] = 1'b1;
                        tag_next[hit_idx]    = '0;
                        status_next          = ST_HIT;
                        slot_next            = SLOT_W'(hit_idx);
                        granted_next         = frame_wanted_reg;
                        stamp_next           = time_reg[hit_idx];
                        field_out_next       = field_reg[hit_idx];
                    end
                    else
                    begin
                        granted_next = granted_miss;
                        if (!camera_off_state_reg)
                        begin
                            requested_frame_next = granted_miss;
                            pending_next         = 1'b1;
                            status_next          = ST_ARMED;
                        end
                        else
                        begin
                            status_next = ST_NA;
                        end
                    end
                end
            end
            MODE_EXTRA_STATS:
            begin
                if (buffers_ready_reg)
                begin
                    if (write_time_reg)
                    begin
                        time_next[past_idx] = time_value_reg;
                    end
                    if (write_field_reg)
                    begin
                        field_next[past_idx] = field_value_reg;
                    end
                end
            end
            MODE_CAMERA_NOTIFY:
            begin
                camera_off_state_next = camera_off_reg;
                if (camera_off_reg && buffers_ready_reg && pending_reg)
                begin
                    pending_next = 1'b0;
                    status_next  = ST_READY;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUFFERS; i++)
            begin
                locked_reg[i] <= 1'b0;
                tag_reg[i]    <= '0;
                time_reg[i]   <= '0;
                field_reg[i]  <= '0;
            end
            active_slot_reg      <= '0;
            frame_counter_reg    <= '0;
            pending_reg          <= 1'b0;
            requested_frame_reg  <= '0;
            camera_off_state_reg <= 1'b0;
        end
        else if (advance)
        begin
            for (int i = 0; i < NUM_BUFFERS; i++)
            begin
                locked_reg[i] <= locked_next[i];
                tag_reg[i]    <= tag_next[i];
                time_reg[i]   <= time_next[i];
                field_reg[i]  <= field_next[i];
            end
            active_slot_reg      <= active_slot_next;
            frame_counter_reg    <= frame_counter_next;
            pending_reg          <= pending_next;
            requested_frame_reg  <= requested_frame_next;
            camera_off_state_reg <= camera_off_state_next;
        end
    end

    // Result register.
    logic [STATUS_W-1:0] status_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [FRAME_W-1:0]  granted_reg;
    logic [TIME_W-1:0]   stamp_reg;
    logic [FIELD_W-1:0]  field_out_reg;
    logic [FRAME_W-1:0]  current_frame_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg        <= status_next;
            slot_reg          <= slot_next;
            granted_reg       <= granted_next;
            stamp_reg         <= stamp_next;
            field_out_reg     <= field_out_next;
            current_frame_reg <= frame_counter_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign slot          = slot_reg;
    assign granted_frame = granted_reg;
    assign stamp         = stamp_reg;
    assign field_out     = field_out_reg;
    assign current_frame = current_frame_reg;

endmodule

`default_nettype wire
